/* sv/awsa_pkg.sv */
package awsa_pkg;

	// block configuration
	localparam int CHANNELS    = 8;
	localparam int SAMPLE_BITS = 10;
	localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// accumulator and counter widths
	localparam int SUM_W   = 27;
	localparam int SQ_W    = 37;
	localparam int ALU_W   = 37;
	localparam int PROD_W  = 2 * SAMPLE_BITS;
	localparam int ROUND_W = 16;
	localparam int FRAME_W = 32;

	// result field widths
	localparam int OUT_CH_W  = 3;
	localparam int OUT_SUM_W = 26;
	localparam int OUT_SQ_W  = 36;

	// stream widths
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_FIELD_W = FRAME_W + OUT_CH_W + OUT_SUM_W + OUT_SQ_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_WINDOW_LENGTH = 1'b0;
	localparam logic [ROUND_W-1:0] WINDOW_RESET = 16'd10000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_SQ,
		ST_ROUND,
		ST_FRAME,
		ST_LOAD,
		ST_EMIT
	} awsa_state_t;

	typedef enum logic [1:0] {
		OP_SUM,
		OP_SQ,
		OP_ROUND,
		OP_FRAME
	} awsa_op_t;

	// sequencer to datapath
	typedef struct packed {
		logic     s_ready;
		logic     m_valid;
		awsa_op_t op;
		logic     en_prod;
		logic     wr_sum;
		logic     wr_sq;
		logic     ptr_adv;
		logic     wr_round;
		logic     wr_frame;
		logic     emit_clr;
		logic     emit_inc;
		logic     load_out;
		logic     clear_acc;
	} awsa_ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic s_accept;
		logic m_accept;
		logic ch_last;
		logic round_match;
		logic emit_last;
	} awsa_stat_t;

endpackage

/* sv/awsa_alu.sv */
module awsa_alu (
	input  logic [awsa_pkg::ALU_W-1:0]   a,
	input  logic [awsa_pkg::ALU_W-1:0]   b,
	input  logic [awsa_pkg::ROUND_W-1:0] cmp,
	output logic [awsa_pkg::ALU_W-1:0]   result,
	output logic                         match
);
	import awsa_pkg::*;

	// shared adder with low-field equality compare
	assign result = a + b;
	assign match  = (result[ROUND_W-1:0] == cmp);

endmodule

/* sv/awsa_ctrl.sv */
module awsa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  awsa_pkg::awsa_stat_t stat,
	output awsa_pkg::awsa_ctrl_t ctrl
);
	import awsa_pkg::*;

	awsa_state_t state_q;
	awsa_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		ctrl.op = OP_SUM;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.s_ready = 1'b1;
				if (stat.s_accept) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				ctrl.en_prod = 1'b1;
				state_d      = ST_SUM;
			end
			ST_SUM: begin
				ctrl.op     = OP_SUM;
				ctrl.wr_sum = 1'b1;
				state_d     = ST_SQ;
			end
			ST_SQ: begin
				ctrl.op      = OP_SQ;
				ctrl.wr_sq   = 1'b1;
				ctrl.ptr_adv = 1'b1;
				state_d      = stat.ch_last ? ST_ROUND : ST_IDLE;
			end
			ST_ROUND: begin
				ctrl.op       = OP_ROUND;
				ctrl.wr_round = 1'b1;
				state_d       = stat.round_match ? ST_FRAME : ST_IDLE;
			end
			ST_FRAME: begin
				ctrl.op       = OP_FRAME;
				ctrl.wr_frame = 1'b1;
				ctrl.emit_clr = 1'b1;
				state_d       = ST_LOAD;
			end
			ST_LOAD: begin
				ctrl.load_out = 1'b1;
				state_d       = ST_EMIT;
			end
			ST_EMIT: begin
				ctrl.m_valid = 1'b1;
				if (stat.m_accept) begin
					if (stat.emit_last) begin
						ctrl.clear_acc = 1'b1;
						state_d        = ST_IDLE;
					end else begin
						ctrl.emit_inc = 1'b1;
						state_d       = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/adc_window_sum_and_square_accumulator_core.sv */
// channel   | direction | fields
// s_axis    | in        | tdata: sample[9:0]
// m_axis    | out       | tdata: frame_number, channel, sum, sum_squares; tlast: last
// apb       | in/out    | window_length at byte address 0
//
// a sample passes accept, square, sum add and square-sum add steps, plus a round count
// update on the last channel; all adds go through one shared 37-bit adder
// a window end adds a frame count step and then a load and an emit step per result
// s_tready is low while a sample or the result burst is in work
// m_tvalid holds until each result transfer, tready low simply stalls the burst
// reset clears the pointer, accumulators, round and frame counts, window to 10000
module adc_window_sum_and_square_accumulator_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [awsa_pkg::IN_TDATA_W-1:0]      s_tdata,   // sample[9:0], zero pad
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [awsa_pkg::OUT_TDATA_W-1:0]     m_tdata,   // frame_number[31:0],
	                                                        // channel[34:32], sum[60:35],
	                                                        // sum_squares[96:61], zero pad
	output logic                                 m_tlast,
	// configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [awsa_pkg::PADDR_W-1:0]         paddr,
	input  logic [awsa_pkg::PDATA_W-1:0]         pwdata,
	output logic [awsa_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready
);
	import awsa_pkg::*;

	awsa_ctrl_t ctrl;
	awsa_stat_t stat;

	logic [ROUND_W-1:0]     window_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [PROD_W-1:0]      prod_q;
	logic [CH_W-1:0]        ch_q;
	logic [CH_W-1:0]        emit_idx_q;
	logic [ROUND_W-1:0]     round_q;
	logic [FRAME_W-1:0]     frame_q;
	logic [SUM_W-1:0]       sum_q [CHANNELS];
	logic [SQ_W-1:0]        sq_q  [CHANNELS];

	logic [CH_W-1:0]        rd_idx;
	logic [SUM_W-1:0]       sum_rd;
	logic [SQ_W-1:0]        sq_rd;
	logic [ALU_W-1:0]       alu_a;
	logic [ALU_W-1:0]       alu_b;
	logic [ALU_W-1:0]       alu_res;
	logic                   alu_match;

	logic [FRAME_W-1:0]     out_frame_q;
	logic [OUT_CH_W-1:0]    out_ch_q;
	logic [OUT_SUM_W-1:0]   out_sum_q;
	logic [OUT_SQ_W-1:0]    out_sq_q;
	logic                   out_last_q;

	logic                   cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == REG_WINDOW_LENGTH)
		? {{(PDATA_W-ROUND_W){1'b0}}, window_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_wr && (paddr[2] == REG_WINDOW_LENGTH)) begin
			window_q <= pwdata[ROUND_W-1:0];
		end
	end

	// sequencer
	assign s_tready       = ctrl.s_ready;
	assign m_tvalid       = ctrl.m_valid;
	assign stat.s_accept  = s_tvalid & ctrl.s_ready;
	assign stat.m_accept  = ctrl.m_valid & m_tready;
	assign stat.ch_last   = (ch_q == CH_W'(CHANNELS - 1));
	assign stat.emit_last = (emit_idx_q == CH_W'(CHANNELS - 1));
	assign stat.round_match = alu_match;

	awsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// one accumulator read port, shared by update and result load
	assign rd_idx = ctrl.load_out ? emit_idx_q : ch_q;
	assign sum_rd = sum_q[rd_idx];
	assign sq_rd  = sq_q[rd_idx];

	// shared adder operand select
	always_comb begin
		unique case (ctrl.op)
			OP_SUM: begin
				alu_a = ALU_W'(sum_rd);
				alu_b = ALU_W'(sample_q);
			end
			OP_SQ: begin
				alu_a = ALU_W'(sq_rd);
				alu_b = ALU_W'(prod_q);
			end
			OP_ROUND: begin
				alu_a = ALU_W'(round_q);
				alu_b = ALU_W'(1);
			end
			OP_FRAME: begin
				alu_a = ALU_W'(frame_q);
				alu_b = ALU_W'(1);
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	awsa_alu u_alu (
		.a      (alu_a),
		.b      (alu_b),
		.cmp    (window_q),
		.result (alu_res),
		.match  (alu_match)
	);

	// sample capture and square
	always_ff @(posedge clk) begin
		if (stat.s_accept) begin
			sample_q <= s_tdata[SAMPLE_BITS-1:0];
		end
		if (ctrl.en_prod) begin
			prod_q <= sample_q * sample_q;
		end
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i] <= '0;
				sq_q[i]  <= '0;
			end
		end else if (ctrl.clear_acc) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i] <= '0;
				sq_q[i]  <= '0;
			end
		end else begin
			if (ctrl.wr_sum) begin
				sum_q[ch_q] <= alu_res[SUM_W-1:0];
			end
			if (ctrl.wr_sq) begin
				sq_q[ch_q] <= alu_res[SQ_W-1:0];
			end
		end
	end

	// channel pointer, round and frame counters, result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q       <= '0;
			round_q    <= '0;
			frame_q    <= '0;
			emit_idx_q <= '0;
		end else begin
			if (ctrl.ptr_adv) begin
				ch_q <= stat.ch_last ? '0 : ch_q + CH_W'(1);
			end
			if (ctrl.wr_round) begin
				round_q <= alu_match ? '0 : alu_res[ROUND_W-1:0];
			end
			if (ctrl.wr_frame) begin
				frame_q <= alu_res[FRAME_W-1:0];
			end
			if (ctrl.emit_clr) begin
				emit_idx_q <= '0;
			end else if (ctrl.emit_inc) begin
				emit_idx_q <= emit_idx_q + CH_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			out_frame_q <= frame_q;
			out_ch_q    <= OUT_CH_W'(emit_idx_q);
			out_sum_q   <= sum_rd[OUT_SUM_W-1:0];
			out_sq_q    <= sq_rd[OUT_SQ_W-1:0];
			out_last_q  <= stat.emit_last;
		end
	end

	assign m_tdata = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}},
		out_sq_q, out_sum_q, out_ch_q, out_frame_q};
	assign m_tlast = out_last_q;

endmodule
